FILE: hdl/dtq_pkg.sv
// Shared types, codes and constants of the deadline timer queue.
package dtq_pkg;

  // Request command codes
  localparam logic [2:0] CMD_SCHED_ABS = 3'd0;
  localparam logic [2:0] CMD_SCHED_REL = 3'd1;
  localparam logic [2:0] CMD_CANCEL    = 3'd2;
  localparam logic [2:0] CMD_POLL      = 3'd3;
  localparam logic [2:0] CMD_CLEAR     = 3'd4;

  // Result status codes
  localparam logic [2:0] ST_DONE    = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_NULL    = 3'd2;
  localparam logic [2:0] ST_NONE    = 3'd3;
  localparam logic [2:0] ST_EXPIRED = 3'd4;

  // Upper bound on entries released by one poll
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned POLL_W      = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CALC,
    S_CANCEL,
    S_POLL,
    S_RESP
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic req_load;
    logic calc;
    logic cancel_step;
    logic poll_pop;
    logic resp_fire;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_cancel;
    logic is_poll;
    logic steps_zero;
    logic poll_due;
    logic poll_more;
  } stat_t;

endpackage

FILE: hdl/dtq_req_if.sv
// Request channel: valid/ready handshake with the command payload.
interface dtq_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  cmd;
  logic [15:0] conn_id;
  logic [31:0] time_value;
  logic [31:0] delay_secs;

  modport source (output valid, output cmd, output conn_id, output time_value,
                  output delay_secs, input ready);
  modport sink (input valid, input cmd, input conn_id, input time_value,
                input delay_secs, output ready);
endinterface

FILE: hdl/dtq_rsp_if.sv
// Result channel: valid/ready handshake with the result payload.
interface dtq_rsp_if;
  logic        valid;
  logic        ready;
  logic [15:0] out_id;
  logic [31:0] out_deadline;
  logic [2:0]  status;
  logic        last;

  modport source (output valid, output out_id, output out_deadline, output status,
                  output last, input ready);
  modport sink (input valid, input out_id, input out_deadline, input status,
                input last, output ready);
endinterface

FILE: hdl/deadline_timer_queue.sv
// Top level of the deadline timer queue: controller plus datapath.
//
// Usage: requests enter on req_i (valid/ready), results leave on rsp_o.
// Each request carries a command: schedule at an absolute deadline,
// schedule at time_value + delay_secs (saturating), cancel all entries of
// an owner, poll due entries, or clear. Owner id 0 is ignored.
// One request is worked on at a time; req_i.ready is high only when idle.
// Steps per request, after the accept in S_IDLE:
//   schedule, clear, unused codes: S_CALC (decode/deadline), then S_RESP.
//   cancel: S_CALC, then S_CANCEL, where the scan walks every entry held
//     one entry per cycle through the shared shift path and then sees
//     the scan done, then S_RESP responds.
//   poll: S_CALC, then S_POLL; one entry leaves the table head per cycle
//     while the receiver takes results; if none is due, S_RESP responds.
// The first result is registered in S_RESP or by the first pop in S_POLL.
// A poll yields one result per released entry (at most 16), last set on the
// final one, or one if none is due; every other request yields one result.
// A stalled receiver holds the result register; the sequencer waits and
// no result is lost or repeated. Reset empties the table at once and
// leaves the block idle; entry contents need no clearing.
module deadline_timer_queue import dtq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  dtq_req_if.sink   req_i,
  dtq_rsp_if.source rsp_o
);

  ctrl_t ctrl;
  stat_t stat;

  // Sequence the request and hold the result valid flag
  dtq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_i.ready),
    .rsp_valid_o (rsp_o.valid),
    .rsp_ready_i (rsp_o.ready),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  // Keep the sorted table and build the result payload
  dtq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .stat_o         (stat),
    .cmd_i          (req_i.cmd),
    .conn_id_i      (req_i.conn_id),
    .time_value_i   (req_i.time_value),
    .delay_secs_i   (req_i.delay_secs),
    .out_id_o       (rsp_o.out_id),
    .out_deadline_o (rsp_o.out_deadline),
    .status_o       (rsp_o.status),
    .last_o         (rsp_o.last)
  );

endmodule

FILE: hdl/dtq_datapath.sv
// Datapath: sorted entry table, request registers and result register.
module dtq_datapath import dtq_pkg::*; #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ctrl_t       ctrl_i,
  output stat_t       stat_o,
  input  logic [2:0]  cmd_i,
  input  logic [15:0] conn_id_i,
  input  logic [31:0] time_value_i,
  input  logic [31:0] delay_secs_i,
  output logic [15:0] out_id_o,
  output logic [31:0] out_deadline_o,
  output logic [2:0]  status_o,
  output logic        last_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned IDX_W = $clog2(DEPTH);

  logic [31:0] dl_mem_q  [DEPTH];
  logic [15:0] own_mem_q [DEPTH];
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] steps_q, steps_d;
  logic [POLL_W-1:0] n_q, n_d;

  logic [2:0]  cmd_q;
  logic [15:0] id_q;
  logic [31:0] tv_q;
  logic [31:0] delay_q;
  logic [31:0] dl_q;

  logic [15:0] out_id_q;
  logic [31:0] out_dl_q;
  logic [2:0]  status_q;
  logic        last_q;

  logic [32:0]      sum;
  logic [31:0]      sat_dl;
  logic [DEPTH-1:0] le;
  logic             id_zero;
  logic             is_sched;
  logic             full;
  logic             do_insert;
  logic             keep;
  logic [CNT_W-1:0] wr_cnt;
  logic [IDX_W-1:0] wr_idx;
  logic [31:0]      rsp_dl;
  logic [2:0]       rsp_status;

  assign sum    = {1'b0, tv_q} + {1'b0, delay_q};
  assign sat_dl = sum[32] ? '1 : sum[31:0];

  assign id_zero   = (id_q == 16'd0);
  assign is_sched  = cmd_q inside {CMD_SCHED_ABS, CMD_SCHED_REL};
  assign full      = (count_q == CNT_W'(DEPTH));
  assign do_insert = is_sched && !id_zero && !full;
  assign keep      = (own_mem_q[0] != id_q);
  assign wr_cnt    = count_q - CNT_W'(1);
  assign wr_idx    = wr_cnt[IDX_W-1:0];

  // Occupied entries due at or before the new deadline form a prefix
  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      le[i] = (CNT_W'(i) < count_q) && (dl_mem_q[i] <= dl_q);
    end
  end

  always_comb begin
    rsp_dl     = 32'd0;
    rsp_status = ST_DONE;
    case (cmd_q)
      CMD_SCHED_ABS, CMD_SCHED_REL: begin
        rsp_dl = dl_q;
        if (id_zero) begin
          rsp_status = ST_NULL;
        end else if (full) begin
          rsp_status = ST_FULL;
        end else begin
          rsp_status = ST_DONE;
        end
      end
      CMD_CANCEL: begin
        rsp_status = id_zero ? ST_NULL : ST_DONE;
      end
      CMD_POLL: begin
        rsp_status = ST_NONE;
      end
      default: begin
        rsp_status = ST_DONE;
      end
    endcase
  end

  always_comb begin
    stat_o.run_cancel = (cmd_q == CMD_CANCEL) && !id_zero;
    stat_o.is_poll    = (cmd_q == CMD_POLL);
    stat_o.steps_zero = (steps_q == '0);
    stat_o.poll_due   = (count_q != '0) && (n_q < POLL_W'(MAX_RESULTS)) &&
                        (dl_mem_q[0] <= tv_q);
    stat_o.poll_more  = (count_q > CNT_W'(1)) && (n_q < POLL_W'(MAX_RESULTS - 1)) &&
                        (dl_mem_q[1] <= tv_q);
  end

  always_comb begin
    count_d = count_q;
    steps_d = steps_q;
    n_d     = n_q;
    if (ctrl_i.calc) begin
      steps_d = count_q;
      n_d     = '0;
    end
    if (ctrl_i.cancel_step) begin
      steps_d = steps_q - CNT_W'(1);
      if (!keep) begin
        count_d = count_q - CNT_W'(1);
      end
    end
    if (ctrl_i.poll_pop) begin
      count_d = count_q - CNT_W'(1);
      n_d     = n_q + POLL_W'(1);
    end
    if (ctrl_i.resp_fire) begin
      if (do_insert) begin
        count_d = count_q + CNT_W'(1);
      end else if (cmd_q == CMD_CLEAR) begin
        count_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      steps_q <= '0;
      n_q     <= '0;
    end else begin
      count_q <= count_d;
      steps_q <= steps_d;
      n_q     <= n_d;
    end
  end

  // Request registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.req_load) begin
      cmd_q   <= cmd_i;
      id_q    <= conn_id_i;
      tv_q    <= time_value_i;
      delay_q <= delay_secs_i;
    end
    if (ctrl_i.calc) begin
      dl_q <= (cmd_q == CMD_SCHED_REL) ? sat_dl : tv_q;
    end
  end

  // Entry table: insert shifts up, cancel and poll shift down
  always_ff @(posedge clk_i) begin
    if (ctrl_i.resp_fire && do_insert) begin
      if (!le[0]) begin
        dl_mem_q[0]  <= dl_q;
        own_mem_q[0] <= id_q;
      end
      for (int i = 1; i < DEPTH; i++) begin
        if (!le[i]) begin
          dl_mem_q[i]  <= le[i-1] ? dl_q : dl_mem_q[i-1];
          own_mem_q[i] <= le[i-1] ? id_q : own_mem_q[i-1];
        end
      end
    end else if (ctrl_i.cancel_step || ctrl_i.poll_pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        dl_mem_q[i]  <= dl_mem_q[i+1];
        own_mem_q[i] <= own_mem_q[i+1];
      end
      // Rotate a kept head to the top of the occupied region
      if (ctrl_i.cancel_step && keep) begin
        dl_mem_q[wr_idx]  <= dl_mem_q[0];
        own_mem_q[wr_idx] <= own_mem_q[0];
      end
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.poll_pop) begin
      out_id_q <= own_mem_q[0];
      out_dl_q <= dl_mem_q[0];
      status_q <= ST_EXPIRED;
      last_q   <= !stat_o.poll_more;
    end else if (ctrl_i.resp_fire) begin
      out_id_q <= id_q;
      out_dl_q <= rsp_dl;
      status_q <= rsp_status;
      last_q   <= 1'b1;
    end
  end

  assign out_id_o       = out_id_q;
  assign out_deadline_o = out_dl_q;
  assign status_o       = status_q;
  assign last_o         = last_q;

endmodule

FILE: hdl/dtq_ctrl.sv
// Controller: sequences one request at a time and owns the result valid flag.
module dtq_ctrl import dtq_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  req_valid_i,
  output logic  req_ready_o,
  output logic  rsp_valid_o,
  input  logic  rsp_ready_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || rsp_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    ctrl_o      = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          ctrl_o.req_load = 1'b1;
          state_d         = S_CALC;
        end
      end
      S_CALC: begin
        ctrl_o.calc = 1'b1;
        if (stat_i.run_cancel) begin
          state_d = S_CANCEL;
        end else if (stat_i.is_poll) begin
          state_d = S_POLL;
        end else begin
          state_d = S_RESP;
        end
      end
      S_CANCEL: begin
        if (stat_i.steps_zero) begin
          state_d = S_RESP;
        end else begin
          ctrl_o.cancel_step = 1'b1;
        end
      end
      S_POLL: begin
        if (!stat_i.poll_due) begin
          state_d = S_RESP;
        end else if (slot_free) begin
          ctrl_o.poll_pop = 1'b1;
          if (!stat_i.poll_more) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RESP: begin
        if (slot_free) begin
          ctrl_o.resp_fire = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl_o.resp_fire || ctrl_o.poll_pop) begin
      out_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign rsp_valid_o = out_valid_q;

endmodule

FILE: hdl/dtq_checker.sv
// Port-level checks of the deadline timer queue and their bind.
module dtq_checker import dtq_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [15:0] rsp_id_i,
  input logic [31:0] rsp_deadline_i,
  input logic [2:0]  rsp_status_i,
  input logic        rsp_last_i
);

  // A stalled result holds its payload
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_id_i) &&
      $stable(rsp_deadline_i) && $stable(rsp_status_i) && $stable(rsp_last_i))
    else $error("stalled result changed");

  // One request at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken while busy");

  // Only expired entries may continue a burst
  a_single_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && (rsp_status_i != ST_EXPIRED) |-> rsp_last_i)
    else $error("non-burst result without last");

  // No new request while a poll burst is unfinished
  a_burst_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_last_i |-> !req_ready_i)
    else $error("ready during poll burst");

  // Status codes stay in range
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (rsp_status_i <= ST_EXPIRED))
    else $error("status code out of range");

endmodule

bind deadline_timer_queue dtq_checker u_dtq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .req_valid_i    (req_i.valid),
  .req_ready_i    (req_i.ready),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .rsp_id_i       (rsp_o.out_id),
  .rsp_deadline_i (rsp_o.out_deadline),
  .rsp_status_i   (rsp_o.status),
  .rsp_last_i     (rsp_o.last)
);
